FILE: design/fffd_pkg.sv
// Package with the types and constants of the fixed frame field deframer.
`timescale 1ns / 1ps

package fffd_pkg;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned ID_W    = 4;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LANE_W  = 2;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;

    localparam logic [POS_W-1:0] POS_HUNT        = 5'd0;
    localparam logic [POS_W-1:0] POS_TIME_FIRST  = 5'd1;
    localparam logic [POS_W-1:0] POS_TIME_LAST   = 5'd4;
    localparam logic [POS_W-1:0] POS_BYTE1_LAST  = 5'd8;
    localparam logic [POS_W-1:0] POS_LIGHT_FIRST = 5'd9;
    localparam logic [POS_W-1:0] POS_LIGHT_LAST  = 5'd10;
    localparam logic [POS_W-1:0] POS_TEMP_FIRST  = 5'd11;
    localparam logic [POS_W-1:0] POS_TEMP_LAST   = 5'd12;
    localparam logic [POS_W-1:0] POS_BYTE2_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_TSET_FIRST  = 5'd16;
    localparam logic [POS_W-1:0] POS_FRAME_LAST  = 5'd19;

    // Offsets from position to id for the single-byte fields.
    localparam logic [POS_W-1:0] BYTE1_ID_OFS = 5'd4;
    localparam logic [POS_W-1:0] BYTE2_ID_OFS = 5'd6;

    localparam logic [ID_W-1:0] ID_TIME   = 4'd0;
    localparam logic [ID_W-1:0] ID_LIGHT  = 4'd5;
    localparam logic [ID_W-1:0] ID_TEMP   = 4'd6;
    localparam logic [ID_W-1:0] ID_TSET   = 4'd10;

    localparam int unsigned TDATA_W = ((ID_W + VALUE_W + 7) / 8) * 8;

    typedef struct packed {
        logic [ID_W-1:0]    field_id;
        logic [VALUE_W-1:0] field_value;
        logic               frame_done;
    } t_result;

endpackage

FILE: design/fixed_frame_field_deframer_core.sv
// Top level of the fixed frame field deframer: frame walk, accumulator and output skid.
`timescale 1ns / 1ps

// Channel  Direction  Ports                              Contents
// input    slave      s_tvalid s_tready s_tdata[7:0]     rx_byte
// output   master     m_tvalid m_tready m_tdata[39:0]    field_id, field_value; m_tlast = frame_done
// config   write      i_cfg_we i_cfg_wdata[7:0]          sync_value
//
// One item is taken per cycle while s_tready is high; a completed field's result is registered in the output register.
// A second output register holds a result when the consumer stalls, and s_tready drops
// only while that register is full. Reset returns the block to hunting for sync with an
// empty accumulator and a sync value of 0xFF.

module fixed_frame_field_deframer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [7:0]                         i_cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fffd_pkg::TDATA_W-1:0]       m_tdata,   // [3:0] field_id, [35:4] field_value
    output logic                               m_tlast
);
    import fffd_pkg::*;

    logic [BYTE_W-1:0]  r_sync;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic [VALUE_W-1:0] acc_sum;
    logic [LANE_W-1:0]  lane;
    logic               use_acc;
    logic               res_valid;
    t_result            res;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;
    logic               accept;
    logic               out_free;
    logic [POS_W-1:0]   id_pos;

    assign s_tready = !r_skid_valid;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    always_comb begin
        lane    = '0;
        use_acc = 1'b0;
        if (r_pos >= POS_TIME_FIRST && r_pos <= POS_TIME_LAST) begin
            lane    = LANE_W'(r_pos - POS_TIME_FIRST);
            use_acc = 1'b1;
        end else if (r_pos >= POS_LIGHT_FIRST && r_pos <= POS_LIGHT_LAST) begin
            lane    = LANE_W'(r_pos - POS_LIGHT_FIRST);
            use_acc = 1'b1;
        end else if (r_pos >= POS_TEMP_FIRST && r_pos <= POS_TEMP_LAST) begin
            lane    = LANE_W'(r_pos - POS_TEMP_FIRST);
            use_acc = 1'b1;
        end else if (r_pos >= POS_TSET_FIRST && r_pos <= POS_FRAME_LAST) begin
            lane    = LANE_W'(r_pos - POS_TSET_FIRST);
            use_acc = 1'b1;
        end
    end

    assign acc_sum = r_acc + (VALUE_W'(s_tdata) << {lane, 3'b000});

    always_comb begin
        n_pos     = r_pos + POS_W'(1);
        n_acc     = r_acc;
        res_valid = 1'b0;
        res       = '0;
        id_pos    = '0;
        if (use_acc) begin
            n_acc = acc_sum;
        end
        if (r_pos == POS_HUNT) begin
            n_pos = (s_tdata == r_sync) ? POS_TIME_FIRST : POS_HUNT;
        end else if (r_pos > POS_FRAME_LAST) begin
            n_pos = POS_HUNT;
        end else if (r_pos == POS_TIME_LAST) begin
            res_valid       = 1'b1;
            res.field_id    = ID_TIME;
            res.field_value = acc_sum;
            n_acc           = '0;
        end else if (r_pos > POS_TIME_LAST && r_pos <= POS_BYTE1_LAST) begin
            id_pos          = r_pos - BYTE1_ID_OFS;
            res_valid       = 1'b1;
            res.field_id    = id_pos[ID_W-1:0];
            res.field_value = VALUE_W'(s_tdata);
        end else if (r_pos == POS_LIGHT_LAST) begin
            res_valid       = 1'b1;
            res.field_id    = ID_LIGHT;
            res.field_value = {16'd0, acc_sum[15:0]};
            n_acc           = '0;
        end else if (r_pos == POS_TEMP_LAST) begin
            res_valid       = 1'b1;
            res.field_id    = ID_TEMP;
            res.field_value = {16'd0, acc_sum[15:0]};
            n_acc           = '0;
        end else if (r_pos > POS_TEMP_LAST && r_pos <= POS_BYTE2_LAST) begin
            id_pos          = r_pos - BYTE2_ID_OFS;
            res_valid       = 1'b1;
            res.field_id    = id_pos[ID_W-1:0];
            res.field_value = VALUE_W'(s_tdata);
        end else if (r_pos == POS_FRAME_LAST) begin
            res_valid       = 1'b1;
            res.field_id    = ID_TSET;
            res.field_value = acc_sum;
            res.frame_done  = 1'b1;
            n_acc           = '0;
            n_pos           = POS_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_acc <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && res_valid) begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = TDATA_W'({r_out.field_value, r_out.field_id});
    assign m_tlast  = r_out.frame_done;

endmodule

FILE: tb/fixed_frame_field_deframer_core_tb.sv
// Self-checking testbench for the fixed frame field deframer: directed and random frames.
`timescale 1ns / 1ps

module fixed_frame_field_deframer_core_tb;

    import fffd_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                typed;
        bit                has;
        t_result           res;
    } t_dir_row;

    localparam t_result NO_FIELD  = '0;
    localparam int      DIR_ROWS  = 23;
    localparam int      PHASES    = 6;
    localparam int      PHASE_LEN = 80;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [7:0]           i_cfg_wdata = 8'h00;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    logic [POS_W-1:0]     walk_pos  = POS_HUNT;
    logic [VALUE_W-1:0]   walk_acc  = '0;
    logic [BYTE_W-1:0]    sync_byte = SYNC_RESET;

    t_result              pending_fields [$];
    t_result              seen_field;
    t_result              want_field;
    int                   errors      = 0;
    bit                   src_gaps    = 1'b1;
    bit                   sink_stalls = 1'b1;

    // The time bytes are all ones, light hits both byte extremes, temperature is all ones, and
    // the time setting is all zeros, so those results are typed in directly.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, NO_FIELD},
        '{8'hFE, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b1, '{ID_TIME, 32'hFFFF_FFFF, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_FIELD},
        '{8'hFF, 1'b0, 1'b0, NO_FIELD},
        '{8'h5A, 1'b0, 1'b0, NO_FIELD},
        '{8'hA5, 1'b0, 1'b0, NO_FIELD},
        '{8'h00, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b1, '{ID_LIGHT, 32'h0000_FF00, 1'b0}},
        '{8'hFF, 1'b1, 1'b0, NO_FIELD},
        '{8'hFF, 1'b1, 1'b1, '{ID_TEMP, 32'h0000_FFFF, 1'b0}},
        '{8'h01, 1'b0, 1'b0, NO_FIELD},
        '{8'h80, 1'b0, 1'b0, NO_FIELD},
        '{8'h7F, 1'b0, 1'b0, NO_FIELD},
        '{8'h00, 1'b1, 1'b0, NO_FIELD},
        '{8'h00, 1'b1, 1'b0, NO_FIELD},
        '{8'h00, 1'b1, 1'b0, NO_FIELD},
        '{8'h00, 1'b1, 1'b1, '{ID_TSET, 32'h0000_0000, 1'b1}},
        '{8'h12, 1'b1, 1'b0, NO_FIELD}
    };

    fixed_frame_field_deframer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_lane(input logic [BYTE_W-1:0] b, input logic [POS_W-1:0] lane);
        walk_acc = walk_acc + ({24'd0, b} << (8 * lane[LANE_W-1:0]));
    endfunction

    // Advances the frame walk by one received byte and returns 1 when a field completes.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic [POS_W-1:0] p;
        p = walk_pos;
        r = NO_FIELD;
        deframe_byte = 1'b0;
        if (p == POS_HUNT) begin
            if (b == sync_byte) begin
                walk_pos = POS_TIME_FIRST;
            end
        end else if (p > POS_FRAME_LAST) begin
            walk_pos = POS_HUNT;
        end else begin
            walk_pos = p + 1'b1;
            if (p <= POS_TIME_LAST) begin
                add_lane(b, p - POS_TIME_FIRST);
                if (p == POS_TIME_LAST) begin
                    r = '{ID_TIME, walk_acc, 1'b0};
                    walk_acc = '0;
                    deframe_byte = 1'b1;
                end
            end else if (p <= POS_BYTE1_LAST) begin
                r = '{ID_W'(p - BYTE1_ID_OFS), {24'd0, b}, 1'b0};
                deframe_byte = 1'b1;
            end else if (p <= POS_LIGHT_LAST) begin
                add_lane(b, p - POS_LIGHT_FIRST);
                if (p == POS_LIGHT_LAST) begin
                    r = '{ID_LIGHT, {16'd0, walk_acc[15:0]}, 1'b0};
                    walk_acc = '0;
                    deframe_byte = 1'b1;
                end
            end else if (p <= POS_TEMP_LAST) begin
                add_lane(b, p - POS_TEMP_FIRST);
                if (p == POS_TEMP_LAST) begin
                    r = '{ID_TEMP, {16'd0, walk_acc[15:0]}, 1'b0};
                    walk_acc = '0;
                    deframe_byte = 1'b1;
                end
            end else if (p <= POS_BYTE2_LAST) begin
                r = '{ID_W'(p - BYTE2_ID_OFS), {24'd0, b}, 1'b0};
                deframe_byte = 1'b1;
            end else begin
                add_lane(b, p - POS_TSET_FIRST);
                if (p == POS_FRAME_LAST) begin
                    r = '{ID_TSET, walk_acc, 1'b1};
                    walk_acc = '0;
                    walk_pos = POS_HUNT;
                    deframe_byte = 1'b1;
                end
            end
        end
    endfunction

    task automatic feed_byte(input logic [BYTE_W-1:0] b, output bit has, output t_result r);
        int gap;
        gap = src_gaps ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        has = deframe_byte(b, r);
    endtask

    task automatic feed_predicted(input logic [BYTE_W-1:0] b);
        bit      has;
        t_result r;
        feed_byte(b, has, r);
        if (has) begin
            pending_fields.push_back(r);
        end
    endtask

    task automatic drain_fields();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sync_byte = v;
    endtask

    // Mostly whole frames with random content, with runs of line noise while hunting.
    task automatic run_frames(input int n_items);
        int                sent;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 5)) feed_predicted(8'($urandom_range(0, 255)));
            end
            feed_predicted(sync_byte);
            repeat (19) begin
                if ($urandom_range(0, 7) == 0) begin
                    b = {8{1'($urandom_range(0, 1))}};
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                feed_predicted(b);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_field = '{m_tdata[ID_W-1:0], m_tdata[ID_W +: VALUE_W], m_tlast};
            if (pending_fields.size() == 0) begin
                errors++;
                $display("%0t: unexpected item id=%0d value=%h done=%b", $time,
                         seen_field.field_id, seen_field.field_value, seen_field.frame_done);
            end else begin
                want_field = pending_fields.pop_front();
                if (seen_field !== want_field) begin
                    errors++;
                    $display("%0t: expected id=%0d value=%h done=%b, got id=%0d value=%h done=%b",
                             $time, want_field.field_id, want_field.field_value,
                             want_field.frame_done, seen_field.field_id,
                             seen_field.field_value, seen_field.frame_done);
                end
            end
        end
    end

    initial begin : sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            @(negedge i_clk);
        end
    end

    initial begin : main
        bit                has;
        t_result           r;
        logic [BYTE_W-1:0] phase_sync [PHASES];
        phase_sync = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, 8'($urandom), 8'h80};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DIR_ROWS; i++) begin
            feed_byte(dir_rows[i].rx, has, r);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].has) begin
                    pending_fields.push_back(dir_rows[i].res);
                end
            end else if (has) begin
                pending_fields.push_back(r);
            end
        end
        for (int p = 0; p < PHASES; p++) begin
            drain_fields();
            write_sync(phase_sync[p]);
            src_gaps    = (p % 3) != 1;
            sink_stalls = (p % 3) != 2;
            run_frames(PHASE_LEN);
        end
        drain_fields();
        if (errors == 0) begin
            $display("fixed_frame_field_deframer_core_tb: clean");
        end else begin
            $display("fixed_frame_field_deframer_core_tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("fixed_frame_field_deframer_core_tb: errors");
        $finish;
    end

endmodule
